### rtl/core/ctt_pkg.sv
package ctt_pkg;

   // Field widths
   localparam int unsigned CaptureW  = 16;
   localparam int unsigned SecondsW  = 17;
   localparam int unsigned MinutesW  = 12;
   localparam int unsigned TickW     = 18;
   localparam int unsigned IdleW     = 16;
   localparam int unsigned MeasW     = 8;
   localparam int unsigned AccW      = 32;
   localparam int unsigned SecShift  = 15;
   localparam int unsigned ReqDataW  = 16;
   localparam int unsigned RspDataW  = 72;

   // Measurement ticks before recalibration
   localparam logic [MeasW-1:0] MEAS_TICKS = 8'd2;

   // Tick length after reset: 3 s of 32768 Hz
   localparam logic [TickW-1:0] TICK_RESET = 18'd98304;
   // Offset added to a capture: one count plus the 16-bit wrap
   localparam logic [TickW-1:0] TICK_OFFSET = 18'd65537;

   // seconds / 60 as (seconds * MIN_RECIP) >> MIN_SHIFT, exact for 17-bit seconds
   localparam int unsigned RecipW = 18;
   localparam logic [RecipW-1:0] MIN_RECIP = 18'd139811;
   localparam int unsigned MinShift = 23;
   localparam int unsigned ProdW = SecondsW + RecipW;

   typedef struct packed {
      logic                meas_mode;
      logic [CaptureW-1:0] capture_count;
   } req_item_type;

   typedef struct packed {
      logic [SecondsW-1:0] seconds;
      logic [TickW-1:0]    tick_length;
      logic [IdleW-1:0]    idle_ticks;
      logic [MeasW-1:0]    meas_ticks;
   } mid_item_type;

endpackage

### rtl/core/ctt_ingress.sv
module ctt_ingress import ctt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,   // [0] meas_mode
   input  logic [ReqDataW-1:0] req_tdata,   // [15:0] capture_count
   output logic                item_valid,
   output req_item_type        item,
   input  logic                item_ready
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign req_tready = !valid_ff || item_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.meas_mode     <= req_tuser;
         item_ff.capture_count <= req_tdata[CaptureW-1:0];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/core/ctt_state_core.sv
module ctt_state_core import ctt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         item_ready,
   output logic         mid_valid,
   output mid_item_type mid,
   input  logic         mid_ready
);

   logic [AccW-1:0]  acc_ff,  acc_in;
   logic [TickW-1:0] tick_ff, tick_in;
   logic [MeasW-1:0] meas_ff, meas_in;
   logic [IdleW-1:0] idle_ff, idle_in;
   logic             mid_valid_ff, mid_valid_in;
   mid_item_type     mid_ff,  mid_in;
   logic             take;

   assign item_ready = !mid_valid_ff || mid_ready;
   assign take       = item_valid && item_ready;

   always_comb begin
      meas_in = meas_ff;
      idle_in = idle_ff;
      tick_in = tick_ff;
      if (item.meas_mode) begin
         idle_in = '0;
         // Saturated counter never re-triggers calibration
         if (meas_ff != '1) begin
            meas_in = meas_ff + 1'b1;
            if (meas_in == MEAS_TICKS) begin
               tick_in = TickW'(item.capture_count) + TICK_OFFSET;
            end
         end
      end else begin
         meas_in = '0;
         if (idle_ff != '1) begin
            idle_in = idle_ff + 1'b1;
         end
      end
      acc_in = acc_ff + AccW'(tick_in);

      mid_in.seconds     = acc_in[SecShift +: SecondsW];
      mid_in.tick_length = tick_in;
      mid_in.idle_ticks  = idle_in;
      mid_in.meas_ticks  = meas_in;

      mid_valid_in = mid_valid_ff;
      if (item_ready) begin
         mid_valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         tick_ff      <= TICK_RESET;
         meas_ff      <= '0;
         idle_ff      <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         if (take) begin
            acc_ff  <= acc_in;
            tick_ff <= tick_in;
            meas_ff <= meas_in;
            idle_ff <= idle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

endmodule

### rtl/core/ctt_egress.sv
module ctt_egress import ctt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                mid_valid,
   input  mid_item_type        mid,
   output logic                mid_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata
);

   logic [ProdW-1:0]    prod;
   logic [MinutesW-1:0] minutes;
   logic                out_valid_ff, out_valid_in;
   logic [RspDataW-1:0] data_ff, data_in;

   assign mid_ready = !out_valid_ff || rsp_tready;

   // Divide by 60 through the reciprocal
   assign prod    = ProdW'(mid.seconds) * ProdW'(MIN_RECIP);
   assign minutes = prod[MinShift +: MinutesW];

   always_comb begin
      data_in = {mid.meas_ticks, mid.idle_ticks, mid.tick_length,
                 !minutes[0], minutes, mid.seconds};
      out_valid_in = out_valid_ff;
      if (mid_ready) begin
         out_valid_in = mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_valid && mid_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

### rtl/core/calibrated_tick_timekeeper.sv
// Calibrated tick timekeeper.
// Each transaction on the req_ channel is one tick of the low-power RTC:
// req_tuser carries the measurement-mode flag, req_tdata the 16-bit crystal
// capture. Each tick yields exactly one rsp_ transaction with seconds,
// minutes, LED level, tick length and the measurement/idle tick counters.
// The req transaction passes through an input register, the state update
// (counters, calibration, 32-bit accumulator) into a middle register, and
// the divide-by-60 multiply into the output register before the rsp
// transaction. One tick is accepted per cycle while rsp_tready stays high;
// the state update (accumulator add, counters, tick length) is the only
// loop and closes through the state registers.
// Reset clears the accumulator and counters and sets the tick length to
// 3 s (98304 units); all stages come out empty.
// When rsp_tready is low the output register holds its transaction, and
// the two stages in front keep accepting until they are full, after which
// req_tready drops.
module calibrated_tick_timekeeper import ctt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,   // [0] meas_mode
   input  logic [ReqDataW-1:0] req_tdata,   // [15:0] capture_count
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [16:0] seconds, [28:17] minutes, [29] led_on, [47:30] tick_length,
   // [63:48] idle_ticks, [71:64] meas_ticks
   output logic [RspDataW-1:0] rsp_tdata
);

   logic         item_valid, item_ready;
   req_item_type item;
   logic         mid_valid, mid_ready;
   mid_item_type mid;

   ctt_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   ctt_state_core u_state_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .mid_valid  (mid_valid),
      .mid        (mid),
      .mid_ready  (mid_ready)
   );

   ctt_egress u_egress (
      .clock      (clock),
      .reset      (reset),
      .mid_valid  (mid_valid),
      .mid        (mid),
      .mid_ready  (mid_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/core/ctt_checker.sv
module ctt_checker import ctt_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata
);

   logic [SecondsW:0] min_x60;

   assign min_x60 = (SecondsW+1)'(rsp_tdata[28:17]) * (SecondsW+1)'(60);

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29] == !rsp_tdata[17])
      else $error("LED level does not follow minute parity");

   // Minutes must be the truncated quotient of seconds by 60
   a_minutes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (min_x60 <= (SecondsW+1)'(rsp_tdata[16:0]))
                  && ((SecondsW+1)'(rsp_tdata[16:0]) < min_x60 + (SecondsW+1)'(60)))
      else $error("minutes inconsistent with seconds");

   a_counters: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:48] == '0) || (rsp_tdata[71:64] == '0))
      else $error("idle and measurement counters both nonzero");

endmodule

bind calibrated_tick_timekeeper ctt_checker u_checker (.*);
